[rtl/assert_macros.svh]
// assertion macros for the rtl top level, which checks itself
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/csrmv_pkg.sv]
// types and constants of the csr sparse matrix-vector multiply block
// no dependencies
package csrmv_pkg;

	localparam int DATA_W      = 32;
	localparam int INDEX_W     = 10;
	localparam int FRAC_W      = 16;
	localparam int ACC_W       = 48;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_MAC   = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic                      in_range;
		logic [INDEX_W-1:0]        index;
		logic signed [DATA_W-1:0]  value;
	} q_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic pop;
		logic close_fire;
	} bk_status_t;

endpackage

[rtl/csrmv_front.sv]
// front end: accepts words, decodes the command, checks the index range
// depends on csrmv_pkg
module csrmv_front #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                                        item_valid,
	output logic                                        item_stall,
	input  logic [1:0]                                  cmd,
	input  logic [csrmv_pkg::INDEX_W-1:0]               index,
	input  logic signed [csrmv_pkg::DATA_W-1:0]         value,
	input  csrmv_pkg::q_status_t                        q_status,
	output logic                                        q_push,
	output csrmv_pkg::q_item_t                          q_item
);

	logic    known;
	csrmv_pkg::op_t op;

	always_comb begin
		known = 1'b1;
		op    = csrmv_pkg::OP_LOAD;
		unique case (cmd)
			csrmv_pkg::CMD_LOAD: begin
				op = csrmv_pkg::OP_LOAD;
			end
			csrmv_pkg::CMD_MAC: begin
				op = csrmv_pkg::OP_MAC;
			end
			csrmv_pkg::CMD_CLOSE: begin
				op = csrmv_pkg::OP_CLOSE;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign item_stall        = q_status.full;
	assign q_push            = item_valid && !q_status.full && known;
	assign q_item.op         = op;
	assign q_item.in_range   = (32'(index) < 32'(VECTOR_DEPTH));
	assign q_item.index      = index;
	assign q_item.value      = value;

endmodule

[rtl/csrmv_fifo.sv]
// short queue between front end and execution back end
// depends on csrmv_pkg
module csrmv_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  csrmv_pkg::q_item_t    push_item,
	input  logic                  pop,
	output csrmv_pkg::q_item_t    head,
	output csrmv_pkg::q_status_t  status
);

	csrmv_pkg::q_item_t                 slot_q [csrmv_pkg::QUEUE_DEPTH];
	logic [csrmv_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [csrmv_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [csrmv_pkg::QCNT_W-1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + csrmv_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + csrmv_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + csrmv_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - csrmv_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == csrmv_pkg::QCNT_W'(csrmv_pkg::QUEUE_DEPTH));

endmodule

[rtl/csrmv_back.sv]
// back end: vector store, multiplier, saturating row accumulator, result register
// depends on csrmv_pkg
module csrmv_back #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csrmv_pkg::q_item_t                  head,
	input  csrmv_pkg::q_status_t                q_status,
	output csrmv_pkg::bk_status_t               bk_status,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [csrmv_pkg::DATA_W-1:0] row_result
);

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int EW = (AW > csrmv_pkg::INDEX_W) ? AW : csrmv_pkg::INDEX_W;
	localparam int SUM_W = csrmv_pkg::ACC_W + 1;

	logic [csrmv_pkg::DATA_W-1:0] mem [VECTOR_DEPTH];

	logic [EW-1:0]                           idx_ext;
	logic [AW-1:0]                           addr;
	logic                                    adv;
	logic                                    pop;
	logic                                    close_fire;

	logic                                    valid_s2;
	csrmv_pkg::op_t                          op_s2;
	logic                                    in_range_s2;
	logic signed [csrmv_pkg::DATA_W-1:0]     value_s2;
	logic signed [csrmv_pkg::DATA_W-1:0]     rdata_s2;
	logic signed [csrmv_pkg::DATA_W-1:0]     elem_s2;
	logic signed [csrmv_pkg::PROD_W-1:0]     prod_full;

	logic                                    valid_s3;
	csrmv_pkg::op_t                          op_s3;
	logic signed [csrmv_pkg::ACC_W-1:0]      prod_s3;

	logic signed [csrmv_pkg::ACC_W-1:0]      row_sum_q;
	logic signed [SUM_W-1:0]                 sum_wide;
	logic signed [csrmv_pkg::ACC_W-1:0]      sum_sat;
	logic signed [csrmv_pkg::DATA_W-1:0]     out_sat;
	logic                                    result_valid_q;
	logic signed [csrmv_pkg::DATA_W-1:0]     row_result_q;

	assign idx_ext    = EW'(head.index);
	assign addr       = idx_ext[AW-1:0];
	assign adv        = !(valid_s3 && op_s3 == csrmv_pkg::OP_CLOSE && result_valid_q
		&& result_stall);
	assign pop        = adv && !q_status.empty;
	assign close_fire = adv && valid_s3 && op_s3 == csrmv_pkg::OP_CLOSE;

	// stage 1: vector store access
	always_ff @(posedge clk) begin
		if (pop && head.op == csrmv_pkg::OP_LOAD && head.in_range) begin
			mem[addr] <= head.value;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_s2    <= mem[addr];
			op_s2       <= head.op;
			in_range_s2 <= head.in_range;
			value_s2    <= head.value;
		end
	end

	// stage 2: multiply, keep q16.16 by dropping low fraction bits
	assign elem_s2   = in_range_s2 ? rdata_s2 : '0;
	assign prod_full = value_s2 * elem_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3   <= op_s2;
			prod_s3 <= prod_full[csrmv_pkg::FRAC_W +: csrmv_pkg::ACC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pop;
			valid_s3 <= valid_s2;
		end
	end

	// stage 3: saturating accumulate and row close
	always_comb begin
		sum_wide = SUM_W'(row_sum_q) + SUM_W'(prod_s3);
		priority if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2]) begin
			sum_sat = sum_wide[SUM_W-1] ? {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[csrmv_pkg::ACC_W-1:0];
		end
		priority if (row_sum_q > csrmv_pkg::ACC_W'(32'sh7fffffff)) begin
			out_sat = {1'b0, {(csrmv_pkg::DATA_W-1){1'b1}}};
		end else if (row_sum_q < -(csrmv_pkg::ACC_W'(33'sh080000000))) begin
			out_sat = {1'b1, {(csrmv_pkg::DATA_W-1){1'b0}}};
		end else begin
			out_sat = row_sum_q[csrmv_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (adv && valid_s3) begin
			unique case (op_s3)
				csrmv_pkg::OP_MAC: begin
					row_sum_q <= sum_sat;
				end
				csrmv_pkg::OP_CLOSE: begin
					row_sum_q <= '0;
				end
				default: begin
					row_sum_q <= row_sum_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (close_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close_fire) begin
			row_result_q <= out_sat;
		end
	end

	assign result_valid         = result_valid_q;
	assign row_result           = row_result_q;
	assign bk_status.pop        = pop;
	assign bk_status.close_fire = close_fire;

endmodule

[rtl/csr_sparse_matrix_vector_multiply.sv]
// csr sparse matrix-vector multiply, q16.16 fixed point
// top level; depends on csrmv_pkg, csrmv_front, csrmv_fifo, csrmv_back, assert_macros.svh
//
// input channel (item_valid / item_stall): one word per item carrying cmd, index, value.
//   cmd load writes value into the vector store at index, cmd mac multiplies value by
//   the stored element at index and adds the product into the row sum, cmd close sends
//   the saturated row sum out and clears it. the fourth code is taken and dropped.
//   an index at or past VECTOR_DEPTH drops a load and makes a mac add zero.
// output channel (result_valid / result_stall): one row_result word per close.
// throughput: one item per cycle unless a stalled result holds a close, set by the single
//   multiply-accumulate path and the one read and one write port of the vector store.
// a close passes the queue, the store read and multiply stage and the accumulate and
//   result register stage before its result shows.
// reset clears the queue, the pipeline, the row sum and the result valid flag;
//   the vector store is not cleared and must be loaded before use.
// while the receiver stalls a pending result, a following close holds the back end,
//   the two-word queue fills and item_stall rises.
`include "assert_macros.svh"

module csr_sparse_matrix_vector_multiply #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          cmd,
	input  logic [csrmv_pkg::INDEX_W-1:0]       index,
	input  logic signed [csrmv_pkg::DATA_W-1:0] value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [csrmv_pkg::DATA_W-1:0] row_result
);

	logic                   q_push;
	csrmv_pkg::q_item_t     q_item;
	csrmv_pkg::q_item_t     q_head;
	csrmv_pkg::q_status_t   q_status;
	csrmv_pkg::bk_status_t  bk_status;

	csrmv_front #(
		.VECTOR_DEPTH (VECTOR_DEPTH)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	csrmv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (bk_status.pop),
		.head      (q_head),
		.status    (q_status)
	);

	csrmv_back #(
		.VECTOR_DEPTH (VECTOR_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_status     (q_status),
		.bk_status    (bk_status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_result   (row_result)
	);

	`ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, bk_status.pop, !q_status.empty)
	`ASSERT_IMPLIES(a_push_not_full, clk, arst_n, q_push, !q_status.full)
	`ASSERT_NEXT(a_close_gives_result, clk, arst_n, bk_status.close_fire, result_valid)
	`ASSERT_IMPLIES(a_result_from_close, clk, arst_n, result_valid && !$past(result_valid),
		$past(bk_status.close_fire))

endmodule

[bench/csr_sparse_matrix_vector_multiply_tb.sv]
// self-checking bench for csr_sparse_matrix_vector_multiply: directed rows, then random rows
// with random idling on both ports; a small class tracks vector store, row sums and due rows
// depends on csrmv_pkg and the rtl top level
module csr_sparse_matrix_vector_multiply_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VEC_DEPTH = 1024;
	localparam int ITEM_GOAL = 500;
	localparam int DRAIN_EVERY = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint ACC_HI = (longint'(1) <<< (csrmv_pkg::ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = 64'sd2147483647;
	localparam longint OUT_LO = -64'sd2147483648;
	localparam logic [csrmv_pkg::DATA_W-1:0] EDGE_VALUES [4] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
	};

	class row_sum_book;
		bit signed [csrmv_pkg::DATA_W-1:0] vec_mem [VEC_DEPTH];
		longint row_acc;
		logic signed [csrmv_pkg::DATA_W-1:0] due_rows [$];
		int fails;

		function new();
			row_acc = 0;
			fails = 0;
		endfunction

		static function longint clamp(longint x, longint lo, longint hi);
			return (x < lo) ? lo : ((x > hi) ? hi : x);
		endfunction

		function void take_item(logic [1:0] c, logic [csrmv_pkg::INDEX_W-1:0] i,
				logic signed [csrmv_pkg::DATA_W-1:0] v);
			longint prod;
			prod = 0;
			case (c)
				csrmv_pkg::CMD_LOAD: begin
					if (i < VEC_DEPTH)
						vec_mem[i] = v;
				end
				csrmv_pkg::CMD_MAC: begin
					// q32.32 product, floor to q16.16
					if (i < VEC_DEPTH)
						prod = (longint'(v) * longint'(vec_mem[i])) >>> csrmv_pkg::FRAC_W;
					row_acc = clamp(row_acc + prod, ACC_LO, ACC_HI);
				end
				csrmv_pkg::CMD_CLOSE: begin
					due_rows.push_back(csrmv_pkg::DATA_W'(clamp(row_acc, OUT_LO, OUT_HI)));
					row_acc = 0;
				end
				default: begin
				end
			endcase
		endfunction

		function void match_row(logic signed [csrmv_pkg::DATA_W-1:0] got);
			logic signed [csrmv_pkg::DATA_W-1:0] want;
			if (due_rows.size() == 0) begin
				$error("row_result: expected none, actual %0d", got);
				fails++;
			end else begin
				want = due_rows.pop_front();
				if (got !== want) begin
					$error("row_result: expected %0d, actual %0d", want, got);
					fails++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] cmd = csrmv_pkg::CMD_LOAD;
	logic [csrmv_pkg::INDEX_W-1:0] index = '0;
	logic signed [csrmv_pkg::DATA_W-1:0] value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [csrmv_pkg::DATA_W-1:0] row_result;

	row_sum_book book = new();
	bit tx_calm;
	bit rx_calm;
	int cycles;
	int sent;
	bit loaded [VEC_DEPTH];
	int loaded_at [$];

	csr_sparse_matrix_vector_multiply #(
		.VECTOR_DEPTH(VEC_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.index(index),
		.value(value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.row_result(row_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			book.take_item(cmd, index, value);
		if (arst_n && result_valid && !result_stall)
			book.match_row(row_result);
	end

	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic logic [csrmv_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return csrmv_pkg::DATA_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			2: return EDGE_VALUES[$urandom_range(0, 3)];
			default: return csrmv_pkg::DATA_W'((int'($urandom_range(0, 16)) - 8) * 65536);
		endcase
	endfunction

	task automatic send_word(logic [1:0] c, int i, logic [csrmv_pkg::DATA_W-1:0] v);
		int gap;
		gap = draw_gap(tx_calm);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
			cmd <= 2'($urandom);
			index <= csrmv_pkg::INDEX_W'($urandom);
			value <= $urandom;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		cmd <= c;
		index <= csrmv_pkg::INDEX_W'(i);
		value <= v;
		do @(posedge clk); while (item_stall);
		if (c != csrmv_pkg::CMD_NONE)
			sent++;
	endtask

	task automatic load_word(int i, logic [csrmv_pkg::DATA_W-1:0] v);
		if (!loaded[i]) begin
			loaded[i] = 1'b1;
			loaded_at.push_back(i);
		end
		send_word(csrmv_pkg::CMD_LOAD, i, v);
	endtask

	task automatic mac_word();
		send_word(csrmv_pkg::CMD_MAC, loaded_at[$urandom_range(0, loaded_at.size() - 1)],
			pick_value());
	endtask

	task automatic wait_rows_done();
		@(negedge clk);
		item_valid <= 1'b0;
		while (book.due_rows.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = draw_gap(rx_calm);
			repeat (hold) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		int roll;
		int row_len;
		int next_drain;
		int n;
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_word(0, 32'h8000_0000);
		load_word(VEC_DEPTH - 1, 32'h7FFF_FFFF);
		load_word(1, 32'h0001_0000);
		load_word(2, 32'hFFFF_0000);
		load_word(3, 32'h0000_0001);
		// empty row
		send_word(csrmv_pkg::CMD_CLOSE, 0, '0);
		send_word(csrmv_pkg::CMD_MAC, 1, 32'h0003_8000);
		send_word(csrmv_pkg::CMD_MAC, 2, 32'h0001_0000);
		send_word(csrmv_pkg::CMD_CLOSE, VEC_DEPTH - 1, 32'hFFFF_FFFF);
		// accumulator pinned at its top, then at its bottom
		repeat (3) send_word(csrmv_pkg::CMD_MAC, 0, 32'h8000_0000);
		send_word(csrmv_pkg::CMD_CLOSE, 0, '0);
		repeat (3) send_word(csrmv_pkg::CMD_MAC, 0, 32'h7FFF_FFFF);
		send_word(csrmv_pkg::CMD_MAC, VEC_DEPTH - 1, 32'h7FFF_FFFF);
		send_word(csrmv_pkg::CMD_CLOSE, 0, '0);
		// negative product below one lsb floors to -1, unused code in between
		send_word(csrmv_pkg::CMD_MAC, 3, 32'hFFFF_FFFF);
		send_word(csrmv_pkg::CMD_NONE, VEC_DEPTH - 1, 32'h7FFF_FFFF);
		send_word(csrmv_pkg::CMD_CLOSE, 0, '0);
		wait_rows_done();

		for (n = 0; n < 40; n++)
			load_word($urandom_range(0, VEC_DEPTH - 1), pick_value());
		next_drain = sent + DRAIN_EVERY;
		while (sent < ITEM_GOAL) begin
			if ($urandom_range(0, 29) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			roll = $urandom_range(0, 19);
			if (roll < 3) begin
				load_word($urandom_range(0, VEC_DEPTH - 1), pick_value());
			end else if (roll == 3) begin
				send_word(csrmv_pkg::CMD_NONE, $urandom_range(0, VEC_DEPTH - 1), $urandom);
			end else begin
				row_len = $urandom_range(0, 8);
				for (k = 0; k < row_len; k++) begin
					roll = $urandom_range(0, 19);
					if (roll < 2)
						load_word($urandom_range(0, VEC_DEPTH - 1), pick_value());
					else if (roll == 2)
						send_word(csrmv_pkg::CMD_NONE, $urandom_range(0, VEC_DEPTH - 1),
							$urandom);
					else
						mac_word();
				end
				send_word(csrmv_pkg::CMD_CLOSE, $urandom_range(0, VEC_DEPTH - 1), $urandom);
			end
			if (sent >= next_drain) begin
				wait_rows_done();
				next_drain = sent + DRAIN_EVERY;
			end
		end

		wait_rows_done();
		repeat (20) @(posedge clk);
		if (book.fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/csrmv_pkg.sv
rtl/csrmv_front.sv
rtl/csrmv_fifo.sv
rtl/csrmv_back.sv
rtl/csr_sparse_matrix_vector_multiply.sv
bench/csr_sparse_matrix_vector_multiply_tb.sv
